>>> hw/rtl/kfpv_pkg.sv
// Shared constants, types and saturation helpers for the two-state Kalman filter.
// Used by kfpv_mul, kfpv_div and kalman_filter_position_velocity; no dependencies.
package kfpv_pkg;

  // Fixed-point format: estimates Q(32-F).F, covariance Q(48-F).F
  localparam int FRAC_BITS = 16;
  localparam int EST_W     = 32;
  localparam int COV_W     = 48;
  localparam int ADD_W     = 52;   // shared adder, holds the four-term covariance sum
  localparam int MUL_W     = 49;   // multiplier operand width (gain k0 needs 49 bits)
  localparam int DEN_W     = 49;   // innovation variance width
  localparam int Y_W       = EST_W + 1;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE = 1'b1;

  // Reset values and the constant one
  localparam logic signed [COV_W-1:0] ONE_COV        = COV_W'(1) << FRAC_BITS;
  localparam logic signed [COV_W-1:0] COV_RST        = COV_W'(1000) << FRAC_BITS;
  localparam logic [EST_W-1:0]        MEAS_NOISE_RST = EST_W'(1) << FRAC_BITS;
  localparam logic [EST_W-1:0]        PROC_NOISE_RST = EST_W'((1 << FRAC_BITS) / 100);

  // Request to the shared multiplier: returns (a*b) >> F, saturated to 48 bits
  typedef struct packed {
    logic                    start;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  // Request to the divider: returns (num << F) / den, saturated to 48 bits
  typedef struct packed {
    logic                    start;
    logic signed [COV_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  // Response of either arithmetic unit
  typedef struct packed {
    logic                    done;
    logic signed [COV_W-1:0] value;
  } unit_rsp_t;

  // Clamp an adder result to the 32-bit estimate range
  function automatic logic signed [EST_W-1:0] sat32(input logic signed [ADD_W-1:0] v);
    logic [ADD_W-EST_W:0]    hi_bits;
    logic signed [EST_W-1:0] r;
    hi_bits = v[ADD_W-1:EST_W-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      r = v[EST_W-1:0];
    end else if (v[ADD_W-1]) begin
      r = {1'b1, {(EST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(EST_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Clamp an adder result to the 48-bit covariance range
  function automatic logic signed [COV_W-1:0] sat48(input logic signed [ADD_W-1:0] v);
    logic [ADD_W-COV_W:0]    hi_bits;
    logic signed [COV_W-1:0] r;
    hi_bits = v[ADD_W-1:COV_W-1];
    if ((&hi_bits) || !(|hi_bits)) begin
      r = v[COV_W-1:0];
    end else if (v[ADD_W-1]) begin
      r = {1'b1, {(COV_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COV_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/kfpv_mul.sv
// Shared sign-magnitude fixed-point multiplier: four 32x32 partial products over cycles.
// Depends on kfpv_pkg for widths, request and response types.
module kfpv_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kfpv_pkg::mul_req_t   req,
  output kfpv_pkg::unit_rsp_t  rsp
);
  import kfpv_pkg::*;

  localparam int LO_W  = 32;
  localparam int HI_W  = MUL_W - LO_W;
  localparam int PP_W  = 2 * LO_W;
  localparam int ACC_W = 2 * MUL_W;

  localparam logic [1:0] MS_IDLE = 2'd0;
  localparam logic [1:0] MS_RUN  = 2'd1;
  localparam logic [1:0] MS_FIN  = 2'd2;
  localparam logic [2:0] STEP_LAST = 3'd4;

  logic [1:0]              state_r;
  logic [2:0]              step_r;
  logic                    neg_r;
  logic                    pv_r;
  logic                    done_r;
  logic [1:0]              psh_r;
  logic [MUL_W-1:0]        ua_r;
  logic [MUL_W-1:0]        ub_r;
  logic [PP_W-1:0]         pp_r;
  logic [ACC_W-1:0]        acc_r;
  logic signed [COV_W-1:0] res_r;

  logic [LO_W-1:0]         a_part;
  logic [LO_W-1:0]         b_part;
  logic [PP_W-1:0]         prod;
  logic [ACC_W-1:0]        term;
  logic [ACC_W-1:0]        rsh;
  logic [COV_W-1:0]        lim;
  logic [COV_W-1:0]        mag;

  // Pick operand halves for this step: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    a_part = step_r[1] ? LO_W'(ua_r[MUL_W-1:LO_W]) : ua_r[LO_W-1:0];
    b_part = step_r[0] ? LO_W'(ub_r[MUL_W-1:LO_W]) : ub_r[LO_W-1:0];
    prod   = a_part * b_part;
  end

  // Align the held partial product to its weight
  always_comb begin
    case (psh_r)
      2'd0:    term = ACC_W'(pp_r);
      2'd1:    term = ACC_W'(pp_r) << LO_W;
      default: term = ACC_W'(pp_r) << (2 * LO_W);
    endcase
  end

  // Drop fraction bits, clamp the magnitude, restore the sign
  always_comb begin
    rsh = acc_r >> FRAC_BITS;
    lim = neg_r ? {1'b1, {(COV_W-1){1'b0}}} : {1'b0, {(COV_W-1){1'b1}}};
    mag = (rsh > ACC_W'(lim)) ? lim : rsh[COV_W-1:0];
  end

  // Sequence the partial products and accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MS_IDLE;
      step_r  <= '0;
      pv_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        MS_IDLE: begin
          if (req.start) begin
            neg_r   <= req.a[MUL_W-1] ^ req.b[MUL_W-1];
            ua_r    <= req.a[MUL_W-1] ? (~req.a + MUL_W'(1)) : req.a;
            ub_r    <= req.b[MUL_W-1] ? (~req.b + MUL_W'(1)) : req.b;
            acc_r   <= '0;
            pv_r    <= 1'b0;
            step_r  <= '0;
            state_r <= MS_RUN;
          end
        end
        MS_RUN: begin
          if (step_r != STEP_LAST) begin
            pp_r  <= prod;
            psh_r <= {1'b0, step_r[0]} + {1'b0, step_r[1]};
          end
          pv_r <= (step_r != STEP_LAST);
          if (pv_r) begin
            acc_r <= acc_r + term;
          end
          step_r <= step_r + 3'd1;
          if (step_r == STEP_LAST) begin
            state_r <= MS_FIN;
          end
        end
        MS_FIN: begin
          res_r   <= neg_r ? (~mag + COV_W'(1)) : mag;
          done_r  <= 1'b1;
          state_r <= MS_IDLE;
        end
        default: state_r <= MS_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

>>> hw/rtl/kfpv_div.sv
// Restoring fixed-point divider, one quotient bit per cycle, with early saturation.
// Depends on kfpv_pkg for widths, request and response types.
module kfpv_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kfpv_pkg::div_req_t   req,
  output kfpv_pkg::unit_rsp_t  rsp
);
  import kfpv_pkg::*;

  localparam int QB    = COV_W - 1;          // quotient bits below the sign
  localparam int SHF   = QB - FRAC_BITS;     // integer quotient bits before saturation
  localparam int CNT_W = $clog2(QB);
  localparam int CMP_W = DEN_W + SHF;

  localparam logic [1:0] DS_IDLE = 2'd0;
  localparam logic [1:0] DS_RUN  = 2'd1;
  localparam logic [1:0] DS_FIN  = 2'd2;

  logic [1:0]              state_r;
  logic [CNT_W-1:0]        cnt_r;
  logic                    neg_r;
  logic                    sat_r;
  logic                    done_r;
  logic [DEN_W-1:0]        den_r;
  logic [DEN_W-1:0]        rem_r;
  logic [QB-1:0]           dsh_r;
  logic [QB-1:0]           quo_r;
  logic signed [COV_W-1:0] res_r;

  logic [COV_W-1:0]        un;
  logic                    start_sat;
  logic [DEN_W:0]          trial;
  logic [DEN_W:0]          diff;
  logic                    ge;
  logic [COV_W-1:0]        mag;

  // Dividend magnitude and the check for a quotient too large for 48 bits
  always_comb begin
    un        = req.num[COV_W-1] ? (~req.num + COV_W'(1)) : req.num;
    start_sat = {{(CMP_W-COV_W){1'b0}}, un} >= {req.den, {SHF{1'b0}}};
  end

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dsh_r[QB-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
    mag   = sat_r ? {1'b0, {QB{1'b1}}} : {1'b0, quo_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        DS_IDLE: begin
          if (req.start) begin
            neg_r   <= req.num[COV_W-1];
            sat_r   <= start_sat;
            den_r   <= req.den;
            rem_r   <= DEN_W'(un >> SHF);
            dsh_r   <= {un[SHF-1:0], {FRAC_BITS{1'b0}}};
            quo_r   <= '0;
            cnt_r   <= CNT_W'(QB - 1);
            state_r <= start_sat ? DS_FIN : DS_RUN;
          end
        end
        DS_RUN: begin
          rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          quo_r <= {quo_r[QB-2:0], ge};
          dsh_r <= dsh_r << 1;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= DS_FIN;
          end
        end
        DS_FIN: begin
          res_r   <= neg_r ? (~mag + COV_W'(1)) : mag;
          done_r  <= 1'b1;
          state_r <= DS_IDLE;
        end
        default: state_r <= DS_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = res_r;

endmodule

>>> hw/rtl/kalman_filter_position_velocity.sv
// Two-state constant-velocity Kalman filter (position, velocity) in fixed point.
// Each input word is one position sample (signed Q16.16); each result word carries the
// updated position and velocity estimates, saturated to 32 bits. The covariance is kept
// in Q32.16. A small sequencer drives one shared 52-bit adder, one multiplier built from
// four 32x32 partial products and a one-bit-per-cycle divider. The time from acceptance
// to result is set mostly by the two gain divisions; a division that saturates ends
// early, and when the innovation variance is not positive both divisions are skipped.
// The input is not ready while a sample is in flight, but a finished result may wait in
// the output register while the next sample is taken. Write meas_noise (index 0) and
// proc_noise (index 1) only while the block is idle.
module kalman_filter_position_velocity (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [kfpv_pkg::EST_W-1:0]      in_measured_position,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [kfpv_pkg::EST_W-1:0]      out_est_position,
  output logic signed [kfpv_pkg::EST_W-1:0]      out_est_velocity,
  input  logic                                   cfg_we,
  input  logic [kfpv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [kfpv_pkg::EST_W-1:0]             cfg_wdata
);
  import kfpv_pkg::*;

  localparam int S_W = DEN_W;

  // Sequencer states
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_POS    = 5'd1;
  localparam logic [4:0] ST_A1     = 5'd2;
  localparam logic [4:0] ST_A2     = 5'd3;
  localparam logic [4:0] ST_A3     = 5'd4;
  localparam logic [4:0] ST_A4     = 5'd5;
  localparam logic [4:0] ST_P01    = 5'd6;
  localparam logic [4:0] ST_P11    = 5'd7;
  localparam logic [4:0] ST_S      = 5'd8;
  localparam logic [4:0] ST_Y      = 5'd9;
  localparam logic [4:0] ST_DIVG   = 5'd10;
  localparam logic [4:0] ST_WG     = 5'd11;
  localparam logic [4:0] ST_K0     = 5'd12;
  localparam logic [4:0] ST_WK1    = 5'd13;
  localparam logic [4:0] ST_MSTART = 5'd14;
  localparam logic [4:0] ST_MWAIT  = 5'd15;
  localparam logic [4:0] ST_EMIT   = 5'd16;

  // Multiply jobs, in issue order
  localparam logic [2:0] MUL_K0Y   = 3'd0;
  localparam logic [2:0] MUL_K1Y   = 3'd1;
  localparam logic [2:0] MUL_GP00  = 3'd2;
  localparam logic [2:0] MUL_GP01  = 3'd3;
  localparam logic [2:0] MUL_K1P01 = 3'd4;

  logic [4:0]              state_r;
  logic [4:0]              state_nxt;
  logic [2:0]              mi_r;

  // Filter state and configuration
  logic signed [EST_W-1:0] pos_r;
  logic signed [EST_W-1:0] vel_r;
  logic signed [COV_W-1:0] p00_r;
  logic signed [COV_W-1:0] p01_r;
  logic signed [COV_W-1:0] p11_r;
  logic [EST_W-1:0]        meas_noise_r;
  logic [EST_W-1:0]        proc_noise_r;

  // Per-sample working registers
  logic signed [EST_W-1:0] z_r;
  logic signed [ADD_W-1:0] acc_r;
  logic signed [COV_W-1:0] pp00_r;
  logic signed [COV_W-1:0] pp01_r;
  logic signed [COV_W-1:0] pp11_r;
  logic signed [S_W-1:0]   s_r;
  logic signed [Y_W-1:0]   y_r;
  logic signed [COV_W-1:0] g_r;
  logic signed [MUL_W-1:0] k0_r;
  logic signed [COV_W-1:0] k1_r;

  // Output register
  logic                    out_valid_r;
  logic signed [EST_W-1:0] out_pos_r;
  logic signed [EST_W-1:0] out_vel_r;

  // Shared adder
  logic signed [ADD_W-1:0] add_a;
  logic signed [ADD_W-1:0] add_b;
  logic                    add_sub;
  logic signed [ADD_W-1:0] add_sum;

  logic                    s_pos;
  logic signed [COV_W-1:0] mres;
  logic signed [COV_W-1:0] dres;
  logic                    out_free;

  mul_req_t                mul_req;
  unit_rsp_t               mul_rsp;
  div_req_t                div_req;
  unit_rsp_t               div_rsp;

  assign s_pos    = !s_r[S_W-1] && (|s_r);
  assign mres     = $signed(mul_rsp.value);
  assign dres     = $signed(div_rsp.value);
  assign out_free = !out_valid_r || out_ready;

  // Route operands to the shared adder for the current step
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      ST_POS: begin
        add_a = ADD_W'(pos_r);
        add_b = ADD_W'(vel_r);
      end
      ST_A1: begin
        add_a = ADD_W'(p00_r);
        add_b = ADD_W'(p01_r);
      end
      ST_A2: begin
        add_a = acc_r;
        add_b = ADD_W'(p01_r);
      end
      ST_A3: begin
        add_a = acc_r;
        add_b = ADD_W'(p11_r);
      end
      ST_A4: begin
        add_a = acc_r;
        add_b = $signed({{(ADD_W-EST_W){1'b0}}, proc_noise_r});
      end
      ST_P01: begin
        add_a = ADD_W'(p01_r);
        add_b = ADD_W'(p11_r);
      end
      ST_P11: begin
        add_a = ADD_W'(p11_r);
        add_b = $signed({{(ADD_W-EST_W){1'b0}}, proc_noise_r});
      end
      ST_S: begin
        add_a = ADD_W'(pp00_r);
        add_b = $signed({{(ADD_W-EST_W){1'b0}}, meas_noise_r});
      end
      ST_Y: begin
        add_a   = ADD_W'(z_r);
        add_b   = ADD_W'(pos_r);
        add_sub = 1'b1;
      end
      ST_K0: begin
        add_a   = ADD_W'(ONE_COV);
        add_b   = ADD_W'(g_r);
        add_sub = 1'b1;
      end
      ST_MWAIT: begin
        case (mi_r)
          MUL_K0Y: begin
            add_a = ADD_W'(pos_r);
            add_b = ADD_W'(mres);
          end
          MUL_K1Y: begin
            add_a = ADD_W'(vel_r);
            add_b = ADD_W'(mres);
          end
          MUL_K1P01: begin
            add_a   = ADD_W'(pp11_r);
            add_b   = ADD_W'(mres);
            add_sub = 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
  end

  // Route operands to the shared multiplier
  always_comb begin
    mul_req.start = (state_r == ST_MSTART);
    case (mi_r)
      MUL_K0Y: begin
        mul_req.a = k0_r;
        mul_req.b = MUL_W'(y_r);
      end
      MUL_K1Y: begin
        mul_req.a = MUL_W'(k1_r);
        mul_req.b = MUL_W'(y_r);
      end
      MUL_GP00: begin
        mul_req.a = MUL_W'(g_r);
        mul_req.b = MUL_W'(pp00_r);
      end
      MUL_GP01: begin
        mul_req.a = MUL_W'(g_r);
        mul_req.b = MUL_W'(pp01_r);
      end
      MUL_K1P01: begin
        mul_req.a = MUL_W'(k1_r);
        mul_req.b = MUL_W'(pp01_r);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  // Divider: g = R/S first, then k1 = P01/S
  always_comb begin
    div_req.start = ((state_r == ST_DIVG) && s_pos) || (state_r == ST_K0);
    div_req.num   = (state_r == ST_K0) ? pp01_r
                                       : $signed({{(COV_W-EST_W){1'b0}}, meas_noise_r});
    div_req.den   = s_r;
  end

  kfpv_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  kfpv_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Advance the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_POS;
      ST_POS:    state_nxt = ST_A1;
      ST_A1:     state_nxt = ST_A2;
      ST_A2:     state_nxt = ST_A3;
      ST_A3:     state_nxt = ST_A4;
      ST_A4:     state_nxt = ST_P01;
      ST_P01:    state_nxt = ST_P11;
      ST_P11:    state_nxt = ST_S;
      ST_S:      state_nxt = ST_Y;
      ST_Y:      state_nxt = ST_DIVG;
      ST_DIVG:   state_nxt = s_pos ? ST_WG : ST_MSTART;
      ST_WG:     if (div_rsp.done) state_nxt = ST_K0;
      ST_K0:     state_nxt = ST_WK1;
      ST_WK1:    if (div_rsp.done) state_nxt = ST_MSTART;
      ST_MSTART: state_nxt = ST_MWAIT;
      ST_MWAIT: begin
        if (mul_rsp.done) begin
          state_nxt = (mi_r == MUL_K1P01) ? ST_EMIT : ST_MSTART;
        end
      end
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Hold state, write back each step's result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mi_r         <= MUL_K0Y;
      pos_r        <= '0;
      vel_r        <= '0;
      p00_r        <= COV_RST;
      p01_r        <= '0;
      p11_r        <= COV_RST;
      meas_noise_r <= MEAS_NOISE_RST;
      proc_noise_r <= PROC_NOISE_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_MEAS_NOISE: meas_noise_r <= cfg_wdata;
          CFG_PROC_NOISE: proc_noise_r <= cfg_wdata;
          default: ;
        endcase
      end

      // Drop the result word once taken, unless a new one replaces it
      if (out_valid_r && out_ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE:  if (in_valid) z_r <= in_measured_position;
        ST_POS:   pos_r  <= sat32(add_sum);
        ST_A1:    acc_r  <= add_sum;
        ST_A2:    acc_r  <= add_sum;
        ST_A3:    acc_r  <= add_sum;
        ST_A4:    pp00_r <= sat48(add_sum);
        ST_P01:   pp01_r <= sat48(add_sum);
        ST_P11:   pp11_r <= sat48(add_sum);
        ST_S:     s_r    <= add_sum[S_W-1:0];
        ST_Y:     y_r    <= add_sum[Y_W-1:0];
        ST_DIVG: begin
          // Non-positive innovation variance: skip the update
          if (!s_pos) begin
            g_r  <= ONE_COV;
            k0_r <= '0;
            k1_r <= '0;
          end
          mi_r <= MUL_K0Y;
        end
        ST_WG:    if (div_rsp.done) g_r <= dres;
        ST_K0:    k0_r <= add_sum[MUL_W-1:0];
        ST_WK1:   if (div_rsp.done) k1_r <= dres;
        ST_MWAIT: begin
          if (mul_rsp.done) begin
            case (mi_r)
              MUL_K0Y:   pos_r <= sat32(add_sum);
              MUL_K1Y:   vel_r <= sat32(add_sum);
              MUL_GP00:  p00_r <= mres;
              MUL_GP01:  p01_r <= mres;
              MUL_K1P01: p11_r <= sat48(add_sum);
              default: ;
            endcase
            mi_r <= mi_r + 3'd1;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pos_r   <= pos_r;
            out_vel_r   <= vel_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_est_position = out_pos_r;
  assign out_est_velocity = out_vel_r;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the two-state position/velocity Kalman filter.
// Needs kfpv_pkg and kalman_filter_position_velocity, which instantiates kfpv_mul and kfpv_div.
module tb;
  import kfpv_pkg::*;

  localparam int     WATCHDOG_LIMIT  = 4000;
  localparam int     DRAIN_CYCLES    = 300;
  localparam int     HOLD_OFF_CYCLES = 400;
  localparam longint ONE_Q           = longint'(1) <<< FRAC_BITS;
  localparam longint COV_MAX         = (longint'(1) <<< (COV_W - 1)) - 1;
  localparam longint COV_MIN         = -(longint'(1) <<< (COV_W - 1));
  localparam longint EST_MAX         = (longint'(1) <<< (EST_W - 1)) - 1;
  localparam longint EST_MIN         = -(longint'(1) <<< (EST_W - 1));

  typedef struct packed {
    logic signed [EST_W-1:0] pos;
    logic signed [EST_W-1:0] vel;
  } estimate_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [EST_W-1:0] in_measured_position = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [EST_W-1:0] out_est_position;
  logic signed [EST_W-1:0] out_est_velocity;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_MEAS_NOISE;
  logic [EST_W-1:0]        cfg_wdata = '0;

  // Filter state and noise settings as the bench tracks them
  logic [EST_W-1:0] kf_meas_noise;
  logic [EST_W-1:0] kf_proc_noise;
  longint           kf_pos, kf_vel, kf_p00, kf_p01, kf_p11;

  logic signed [EST_W-1:0] sample_queue[$];
  estimate_t               est_expected[$];

  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int rx_hold_cycles = 0;
  int idle_cycles    = 0;
  int mismatch_count = 0;
  bit sample_taken   = 1'b0;

  kalman_filter_position_velocity u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_measured_position (in_measured_position),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_est_position     (out_est_position),
    .out_est_velocity     (out_est_velocity),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clamp64(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint fit_est(longint v);
    return clamp64(v, EST_MIN, EST_MAX);
  endfunction

  function automatic longint fit_cov(longint v);
    return clamp64(v, COV_MIN, COV_MAX);
  endfunction

  // Fixed-point product: magnitude truncated, then clamped to the covariance range
  function automatic longint fx_mul(longint a, longint b);
    logic [63:0]  ua, ub;
    logic [127:0] prod, lim;
    bit           neg;
    neg  = (a < 0) != (b < 0);
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    prod = ({64'd0, ua} * {64'd0, ub}) >> FRAC_BITS;
    lim  = neg ? (128'd1 << (COV_W - 1)) : 128'(COV_MAX);
    if (prod > lim) prod = lim;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  // Fixed-point quotient for a positive divisor; large magnitudes clamp early
  function automatic longint fx_div(longint num, longint den);
    logic [63:0]  un, ud, res;
    logic [127:0] wide;
    un = (num < 0) ? -num : num;
    ud = den;
    if (un / ud >= (64'd1 << (COV_W - 1 - FRAC_BITS))) begin
      res = COV_MAX;
    end else begin
      wide = ({64'd0, un} << FRAC_BITS) / {64'd0, ud};
      res  = wide[63:0];
    end
    return (num < 0) ? -longint'(res) : longint'(res);
  endfunction

  task automatic kf_reset_state();
    kf_meas_noise = MEAS_NOISE_RST;
    kf_proc_noise = PROC_NOISE_RST;
    kf_pos        = 0;
    kf_vel        = 0;
    kf_p00        = longint'(COV_RST);
    kf_p01        = 0;
    kf_p11        = longint'(COV_RST);
  endtask

  // Advance the tracked filter by one position sample and queue the estimate it yields
  task automatic kf_track_sample(input logic signed [EST_W-1:0] z_in);
    longint    z, qn, rn, p00, p01, p11, s, g, k0, k1, y;
    estimate_t want;
    z  = longint'(z_in);
    qn = longint'(kf_proc_noise);
    rn = longint'(kf_meas_noise);
    // predict
    kf_pos = fit_est(kf_pos + kf_vel);
    p00    = fit_cov(kf_p00 + 2 * kf_p01 + kf_p11 + qn);
    p01    = fit_cov(kf_p01 + kf_p11);
    p11    = fit_cov(kf_p11 + qn);
    // update; skip it when the innovation variance is not positive
    s = p00 + rn;
    if (s > 0) begin
      g  = fx_div(rn, s);
      k0 = ONE_Q - g;
      k1 = fx_div(p01, s);
    end else begin
      g  = ONE_Q;
      k0 = 0;
      k1 = 0;
    end
    y      = z - kf_pos;
    kf_pos = fit_est(kf_pos + fx_mul(k0, y));
    kf_vel = fit_est(kf_vel + fx_mul(k1, y));
    kf_p00 = fx_mul(g, p00);
    kf_p01 = fx_mul(g, p01);
    kf_p11 = fit_cov(p11 - fx_mul(k1, p01));
    want.pos = kf_pos[EST_W-1:0];
    want.vel = kf_vel[EST_W-1:0];
    est_expected.push_back(want);
  endtask

  task automatic note_mismatch(input string what, input logic [EST_W-1:0] got,
                               input logic [EST_W-1:0] want);
    $display("estimate mismatch, %s: got %h, want %h", what, got, want);
    mismatch_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [EST_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_MEAS_NOISE: kf_meas_noise = value;
      CFG_PROC_NOISE: kf_proc_noise = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_pacing(input int tx_pct, input int rx_pct);
    @(posedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Mostly noisy constant-velocity tracks, the rest raw full-range words
  task automatic queue_random_samples(input int count);
    longint track_pos, track_vel, amp;
    int     seg;
    while (count > 0) begin
      if ($urandom_range(3) == 0) begin
        sample_queue.push_back($urandom);
        count--;
      end else begin
        track_pos = longint'(int'($urandom)) >>> $urandom_range(12);
        track_vel = longint'(int'($urandom)) >>> $urandom_range(24, 8);
        amp       = longint'(1) <<< $urandom_range(20, 4);
        seg       = $urandom_range(40, 8);
        while (seg > 0 && count > 0) begin
          track_pos = fit_est(track_pos + track_vel);
          sample_queue.push_back(EST_W'(
            fit_est(track_pos + longint'($urandom_range(int'(2 * amp))) - amp)));
          seg--;
          count--;
        end
      end
    end
  endtask

  // Block until every queued sample is taken and every estimate has come back
  task automatic drain_filter();
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || est_expected.size() != 0);
  endtask

  // Offer the next sample, or hold the current word until it is taken
  always @(negedge clk) begin : drive_samples
    if (rst_n && (!in_valid || sample_taken)) begin
      sample_taken = 1'b0;
      if (sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid             <= 1'b1;
        in_measured_position <= sample_queue.pop_front();
      end else begin
        in_valid             <= 1'b0;
        in_measured_position <= $urandom;
      end
    end
  end

  // Receiver pacing, with an optional long hold-off
  always @(negedge clk) begin : drive_ready
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Check returned estimates, then predict for a sample taken at this edge
  always @(posedge clk) begin : watch_ports
    estimate_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (est_expected.size() == 0) begin
          note_mismatch("unexpected word (pos, vel)", out_est_position, out_est_velocity);
        end else begin
          want = est_expected.pop_front();
          if (out_est_position !== want.pos)
            note_mismatch("est_position", out_est_position, want.pos);
          if (out_est_velocity !== want.vel)
            note_mismatch("est_velocity", out_est_velocity, want.vel);
        end
      end
      if (in_valid && in_ready) begin
        kf_track_sample(in_measured_position);
        sample_taken = 1'b1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin : watchdog
    do @(posedge clk);
    while (idle_cycles < WATCHDOG_LIMIT);
    $display("kalman_filter_position_velocity verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [EST_W-1:0] opening_samples [20] = '{
      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000,
      32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 32'h0006_0000,
      32'hFFFF_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h7FFF_FFFF, 32'h0000_0000
    };
    kf_reset_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset noise settings: field extremes, saturating steps, a ramp
    foreach (opening_samples[i]) sample_queue.push_back(opening_samples[i]);
    drain_filter();

    // Smallest measurement noise, no process noise
    write_reg(CFG_MEAS_NOISE, 32'd1);
    write_reg(CFG_PROC_NOISE, '0);
    queue_random_samples(120);
    drain_filter();

    // Largest noise on both, sparse sender
    write_reg(CFG_MEAS_NOISE, '1);
    write_reg(CFG_PROC_NOISE, '1);
    set_pacing(83, 0);
    queue_random_samples(120);
    drain_filter();

    // Zero measurement noise: the position gain is exactly one
    write_reg(CFG_MEAS_NOISE, '0);
    write_reg(CFG_PROC_NOISE, $urandom >> $urandom_range(24, 8));
    set_pacing(0, 83);
    queue_random_samples(120);
    drain_filter();

    // Back to reset values; a long receiver hold-off makes the input stall
    write_reg(CFG_MEAS_NOISE, MEAS_NOISE_RST);
    write_reg(CFG_PROC_NOISE, PROC_NOISE_RST);
    set_pacing(31, 31);
    rx_hold_cycles = HOLD_OFF_CYCLES;
    queue_random_samples(300);
    drain_filter();

    // Random noise settings at full rate
    write_reg(CFG_MEAS_NOISE, $urandom >> $urandom_range(31));
    write_reg(CFG_PROC_NOISE, $urandom >> $urandom_range(31));
    set_pacing(0, 0);
    queue_random_samples(290);
    drain_filter();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("kalman_filter_position_velocity verification clean");
    end else begin
      $display("kalman_filter_position_velocity verification failed");
    end
    $finish;
  end

endmodule
